FILE: hdl/pott_pkg.sv
// Package with the shared types and codes of the timer table.
package pott_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int IDX_W = $clog2(MAX_TIMERS);
  localparam int CNT_W = $clog2(MAX_TIMERS + 1);

  // Operation codes carried in tuser.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FIRED     = 3'd3;
  localparam logic [2:0] ST_TICK_DONE = 3'd4;

  // One stored timer.
  typedef struct packed {
    logic [31:0] id;
    logic        kind;
    logic [31:0] interval;
    logic [31:0] at_time;
    logic [31:0] fire_at;
    logic        enabled;
    logic        del_flag;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_OUT
  } state_t;

  // Saturating 32-bit add.
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

FILE: hdl/pott_ram.sv
// Single-port-write, single-read timer entry memory with registered read data.
module pott_ram
  import pott_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [MAX_TIMERS];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/periodic_oneshot_timer_table.sv
// Top level of the timer table: operation sequencer around the entry memory.
//
//  channel | signals                      | content
//  s_axis  | tvalid tready tdata tuser    | one operation
//  m_axis  | tvalid tready tdata tlast    | one result
//
// An add steps from one accepted transaction to the next through slot write,
// result and idle. Remove and start read, then evaluate, each entry examined,
// and remove also reads and writes each entry moved down.
// A tick first counts its deletions in a read and evaluate pass over all
// entries, so every result carries the final count, then fires in a second
// such pass, moving slots down after each deletion and giving one result per
// firing. Remove without a match, start and tick end with the end check, a
// result and idle. Reset empties the table at once; no clearing pass is needed.
// A result waits in the output register until taken; the sequencer holds
// while it waits, and a new operation is taken once the last result has left.
module periodic_oneshot_timer_table
  import pott_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: now[31:0], job_id[63:32], job_kind[64], period[96:65],
  // at_time[128:97], drop_on_fire[129], zero fill [135:130]
  input  logic [135:0] s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status[2:0], fired_id[34:3], was_deleted[35], timer_count[40:36],
  // zero fill [47:41]
  output logic [47:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  state_t state, state_next;

  logic [1:0]  op;
  logic [31:0] now, job_id, ival, at_t;
  logic        jkind, jdel;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] res_count;  // table count reported with every result
  logic [CNT_W-1:0] idx;
  logic [IDX_W-1:0] mv;         // slot being filled while the table closes a gap
  logic        pre;             // tick is in its counting pass

  logic        we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t      wdata, rdata;

  logic        o_valid;
  logic [2:0]  o_status;
  logic [31:0] o_id;
  logic        o_del, o_last;
  logic        o_done;   // final result of the operation

  pott_ram u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  logic in_fire;
  assign s_axis_tready = (state == S_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  logic out_fire;
  assign out_fire = o_valid && m_axis_tready;

  // Decisions on the entry just read.
  logic        due;
  logic        drop_due;
  logic        hit;
  entry_t      upd;
  logic        at_end;
  logic        last_slot;
  logic        mv_end;
  always_comb begin
    at_end = (idx >= count);
    last_slot = ({1'b0, idx} + 1'b1) >= {1'b0, count};
    mv_end = ({1'b0, mv} + 1'b1) >= count;
    due = rdata.enabled && (rdata.fire_at != 32'd0) && (rdata.fire_at <= now);
    drop_due = due && rdata.kind && rdata.del_flag;
    hit = (op == OP_REMOVE) && (rdata.id == job_id);
    upd = rdata;
    if (op == OP_START) begin
      if (rdata.enabled && rdata.fire_at == 32'd0) begin
        if (!rdata.kind) begin
          upd.fire_at = sat_add(now, rdata.interval);
        end else if (rdata.at_time > now) begin
          upd.fire_at = rdata.at_time;
        end
      end
    end else if (!rdata.kind) begin
      upd.fire_at = sat_add(now, rdata.interval);
    end else begin
      upd.enabled = 1'b0;
      upd.fire_at = 32'd0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (op == OP_ADD) begin
          state_next = S_OUT;
        end else if (at_end) begin
          state_next = pre ? S_READ : S_OUT;
        end else begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (pre) begin
          state_next = S_READ;
        end else if (hit) begin
          state_next = last_slot ? S_OUT : S_SHIFT_RD;
        end else if (op == OP_TICK && due) begin
          state_next = (drop_due && !last_slot) ? S_SHIFT_RD : S_OUT;
        end else begin
          state_next = S_READ;
        end
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: state_next = mv_end ? S_OUT : S_SHIFT_RD;
      S_OUT: begin
        if (out_fire) begin
          state_next = o_done ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory access control.
  always_comb begin
    we = 1'b0;
    waddr = idx[IDX_W-1:0];
    wdata = upd;
    raddr = idx[IDX_W-1:0];
    case (state)
      S_READ: begin
        if (op == OP_ADD && count < CNT_W'(MAX_TIMERS)) begin
          we = 1'b1;
          waddr = count[IDX_W-1:0];
          wdata.id = job_id;
          wdata.kind = jkind;
          wdata.interval = ival;
          wdata.at_time = at_t;
          wdata.del_flag = jdel;
          wdata.enabled = 1'b1;
          if (!jkind) begin
            wdata.fire_at = sat_add(now, ival);
          end else if (at_t > now) begin
            wdata.fire_at = at_t;
          end else begin
            wdata.fire_at = 32'd0;
            wdata.enabled = 1'b0;
          end
        end
      end
      S_EVAL: begin
        we = !pre && ((op == OP_START) || (op == OP_TICK && due && !drop_due));
      end
      S_SHIFT_RD: raddr = mv + IDX_W'(1);
      S_SHIFT_WR: begin
        we = 1'b1;
        waddr = mv;
        wdata = rdata;
      end
      default: ;
    endcase
  end

  // Sequencer registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      res_count <= '0;
      pre <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_fire) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            op        <= s_axis_tuser;
            now       <= s_axis_tdata[31:0];
            job_id    <= s_axis_tdata[63:32];
            jkind     <= s_axis_tdata[64];
            ival      <= s_axis_tdata[96:65];
            at_t      <= s_axis_tdata[128:97];
            jdel      <= s_axis_tdata[129];
            idx       <= '0;
            pre       <= (s_axis_tuser == OP_TICK);
            res_count <= count;
          end
        end
        S_READ: begin
          if (op == OP_ADD) begin
            o_id <= 32'd0;
            o_del <= 1'b0;
            o_done <= 1'b1;
            if (count < CNT_W'(MAX_TIMERS)) begin
              o_status <= ST_OK;
              count <= count + 1'b1;
              res_count <= count + 1'b1;
            end else begin
              o_status <= ST_FULL;
            end
          end else if (at_end) begin
            if (pre) begin
              // Counting pass done: the firing pass starts over from slot zero.
              pre <= 1'b0;
              idx <= '0;
            end else begin
              o_id <= 32'd0;
              o_del <= 1'b0;
              o_done <= 1'b1;
              case (op)
                OP_REMOVE: o_status <= ST_NOT_FOUND;
                OP_TICK:   o_status <= ST_TICK_DONE;
                default:   o_status <= ST_OK;
              endcase
            end
          end
        end
        S_EVAL: begin
          if (pre) begin
            if (drop_due) begin
              res_count <= res_count - 1'b1;
            end
            idx <= idx + 1'b1;
          end else if (hit) begin
            o_status <= ST_OK;
            o_id <= 32'd0;
            o_del <= 1'b0;
            o_done <= 1'b1;
            count <= count - 1'b1;
            res_count <= count - 1'b1;
            mv <= idx[IDX_W-1:0];
          end else if (op == OP_TICK && due) begin
            o_status <= ST_FIRED;
            o_id <= rdata.id;
            o_done <= 1'b0;
            if (drop_due) begin
              // The slot keeps its index so the entry moved into it is examined next.
              o_del <= 1'b1;
              count <= count - 1'b1;
              mv <= idx[IDX_W-1:0];
            end else begin
              o_del <= 1'b0;
              idx <= idx + 1'b1;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SHIFT_WR: mv <= mv + 1'b1;
        default: ;
      endcase
      // Results become visible on entry to the output state.
      if (state != S_OUT && state_next == S_OUT) begin
        o_valid <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = o_valid;
  assign o_last = o_done;
  assign m_axis_tlast = o_last;
  assign m_axis_tdata = {7'd0, res_count, o_del, o_id, o_status};

  // The table never holds more than its capacity.
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(MAX_TIMERS))
    else $error("timer count beyond capacity");
  // No operation is taken while a result is pending.
  assert property (@(posedge clk) disable iff (rst) o_valid |-> !s_axis_tready)
    else $error("input taken while result pending");
  // A fired result never carries the last mark.
  assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_status == ST_FIRED) |-> !m_axis_tlast)
    else $error("fired result marked last");

endmodule

FILE: verif/periodic_oneshot_timer_table_checker.sv
// Checker for the timer table: watches both channels, predicts results and compares them.
module periodic_oneshot_timer_table_checker
  import pott_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [47:0]  m_axis_tdata,
  input  logic         m_axis_tlast,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] fired_id;
    logic        was_deleted;
    logic [4:0]  timer_count;
    logic        last;
  } timer_result_t;

  // Shadow copy of the timer table.
  entry_t        shadow [MAX_TIMERS];
  int unsigned   shadow_count;
  timer_result_t expected_results [$];

  function automatic logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic drop_timer(int unsigned idx);
    for (int unsigned j = idx; j + 1 < shadow_count; j++) shadow[j] = shadow[j + 1];
    shadow_count--;
  endtask

  task automatic push_result(logic [2:0] st, logic [31:0] id, logic del, logic lst);
    timer_result_t r;
    r.status = st;
    r.fired_id = id;
    r.was_deleted = del;
    r.timer_count = '0;
    r.last = lst;
    expected_results.push_back(r);
  endtask

  // Apply one operation to the shadow table and queue its results.
  task automatic predict_operation(logic [1:0] op, logic [135:0] d);
    logic [31:0] now, jid, ivl, at;
    logic        jkind, del;
    int unsigned i, first;
    bit          found;
    now = d[31:0];
    jid = d[63:32];
    jkind = d[64];
    ivl = d[96:65];
    at = d[128:97];
    del = d[129];
    first = expected_results.size();
    case (op)
      OP_ADD: begin
        if (shadow_count >= MAX_TIMERS) begin
          push_result(ST_FULL, '0, 1'b0, 1'b1);
        end else begin
          i = shadow_count;
          shadow[i].id = jid;
          shadow[i].kind = jkind;
          shadow[i].interval = ivl;
          shadow[i].at_time = at;
          shadow[i].del_flag = del;
          shadow[i].enabled = 1'b1;
          if (!jkind) begin
            shadow[i].fire_at = add_clamped(now, ivl);
          end else if (at > now) begin
            shadow[i].fire_at = at;
          end else begin
            shadow[i].fire_at = '0;
            shadow[i].enabled = 1'b0;
          end
          shadow_count++;
          push_result(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      OP_REMOVE: begin
        found = 0;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow[i].id == jid) begin
            drop_timer(i);
            found = 1;
            break;
          end
        end
        push_result(found ? ST_OK : ST_NOT_FOUND, '0, 1'b0, 1'b1);
      end
      OP_START: begin
        for (i = 0; i < shadow_count; i++) begin
          if (shadow[i].enabled && shadow[i].fire_at == 0) begin
            if (!shadow[i].kind) shadow[i].fire_at = add_clamped(now, shadow[i].interval);
            else if (shadow[i].at_time > now) shadow[i].fire_at = shadow[i].at_time;
          end
        end
        push_result(ST_OK, '0, 1'b0, 1'b1);
      end
      default: begin
        i = 0;
        while (i < shadow_count) begin
          if (!shadow[i].enabled || shadow[i].fire_at == 0 || shadow[i].fire_at > now) begin
            i++;
          end else if (!shadow[i].kind) begin
            push_result(ST_FIRED, shadow[i].id, 1'b0, 1'b0);
            shadow[i].fire_at = add_clamped(now, shadow[i].interval);
            i++;
          end else if (shadow[i].del_flag) begin
            push_result(ST_FIRED, shadow[i].id, 1'b1, 1'b0);
            drop_timer(i);
          end else begin
            push_result(ST_FIRED, shadow[i].id, 1'b0, 1'b0);
            shadow[i].enabled = 1'b0;
            shadow[i].fire_at = '0;
            i++;
          end
        end
        push_result(ST_TICK_DONE, '0, 1'b0, 1'b1);
      end
    endcase
    // Every result of one operation carries the count after the whole operation.
    for (int k = first; k < expected_results.size(); k++)
      expected_results[k].timer_count = shadow_count[4:0];
  endtask

  // Watch both channels and compare each result transaction.
  always @(posedge clk) begin
    timer_result_t exp_r;
    int            errs;
    errs = 0;
    if (rst) begin
      shadow_count = 0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_operation(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with no expectation: tdata=%h last=%b", m_axis_tdata, m_axis_tlast);
          errs++;
        end else begin
          exp_r = expected_results.pop_front();
          if (m_axis_tdata[2:0] !== exp_r.status) begin
            $error("status: expected %0d actual %0d", exp_r.status, m_axis_tdata[2:0]);
            errs++;
          end
          if (m_axis_tdata[34:3] !== exp_r.fired_id) begin
            $error("fired_id: expected %h actual %h", exp_r.fired_id, m_axis_tdata[34:3]);
            errs++;
          end
          if (m_axis_tdata[35] !== exp_r.was_deleted) begin
            $error("was_deleted: expected %b actual %b", exp_r.was_deleted, m_axis_tdata[35]);
            errs++;
          end
          if (m_axis_tdata[40:36] !== exp_r.timer_count) begin
            $error("timer_count: expected %0d actual %0d", exp_r.timer_count,
                   m_axis_tdata[40:36]);
            errs++;
          end
          if (m_axis_tlast !== exp_r.last) begin
            $error("last: expected %b actual %b", exp_r.last, m_axis_tlast);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= expected_results.size();
    end
  end
endmodule

FILE: verif/periodic_oneshot_timer_table_tb.sv
// Testbench top for the timer table: stimulus, stalls, watchdog and verdict.
module periodic_oneshot_timer_table_tb;
  import pott_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = OP_ADD;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tlast;
  int           fail_count;
  int           pending;
  int           send_idle_pct = 7;
  int           recv_idle_pct = 67;
  int           idle_cycles = 0;
  logic [31:0]  id_pool [8] = '{32'h1, 32'h2, 32'h3, 32'h4, 32'hFFFF_FFFF, 32'h0, 32'hA5, 32'h7};

  always #6 clk = ~clk;

  periodic_oneshot_timer_table dut (.*);

  periodic_oneshot_timer_table_checker u_checker (.*);

  // Receiver stalls at random.
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Present one operation and hold it until taken.
  task automatic send_operation(logic [1:0] op, logic [31:0] now, logic [31:0] jid,
                                logic jkind, logic [31:0] ivl, logic [31:0] at,
                                logic del);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {6'b0, del, at, ivl, jkind, jid, now};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_random_operation(logic [31:0] base);
    logic [1:0]  op;
    logic [31:0] now, ivl, at;
    int          r;
    r = $urandom_range(99);
    op = (r < 40) ? OP_ADD : (r < 55) ? OP_REMOVE : (r < 65) ? OP_START : OP_TICK;
    // Mostly small times around a moving base so timers really fire; sometimes raw noise.
    if ($urandom_range(9) == 0) begin
      now = $urandom();
      ivl = $urandom();
      at = $urandom();
    end else begin
      now = base + $urandom_range(40);
      ivl = $urandom_range(30);
      at = base + $urandom_range(60);
    end
    send_operation(op, now, ($urandom_range(3) == 0) ? $urandom() : id_pool[$urandom_range(7)],
                   1'($urandom_range(1)), ivl, at, 1'($urandom_range(1)));
  endtask

  initial begin
    logic [31:0] base;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fill the table past full, cover saturation and expired one-shot timers.
    send_operation(OP_TICK, 32'd0, '0, 1'b0, '0, '0, 1'b0);
    send_operation(OP_REMOVE, '0, 32'h1, 1'b0, '0, '0, 1'b0);
    send_operation(OP_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, '0, 1'b0);
    send_operation(OP_ADD, 32'hFFFF_FFFF, 32'h1, 1'b0, 32'h1, '0, 1'b0);
    send_operation(OP_ADD, 32'd10, 32'h2, 1'b1, '0, 32'd5, 1'b1);
    send_operation(OP_ADD, 32'd10, 32'h3, 1'b1, '0, 32'd20, 1'b1);
    send_operation(OP_ADD, 32'd10, 32'h4, 1'b1, '0, 32'd21, 1'b0);
    send_operation(OP_ADD, 32'd0, 32'h0, 1'b0, 32'd0, 32'hFFFF_FFFF, 1'b1);
    send_operation(OP_ADD, 32'd1, 32'h5, 1'b0, 32'd4, '0, 1'b0);
    send_operation(OP_START, 32'd3, '0, 1'b0, '0, '0, 1'b0);
    send_operation(OP_TICK, 32'd25, '0, 1'b0, '0, '0, 1'b0);
    for (int k = 0; k < 11; k++)
      send_operation(OP_ADD, 32'd30, 32'h100 + k, k[0], 32'd3, 32'd40, k[1]);
    send_operation(OP_TICK, 32'hFFFF_FFFF, '0, 1'b0, '0, '0, 1'b0);
    send_operation(OP_REMOVE, '0, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0);
    send_operation(OP_START, 32'hFFFF_FFFF, '0, 1'b0, '0, '0, 1'b0);
    for (int k = 0; k < 17; k++) send_operation(OP_REMOVE, '0, 32'h100 + k, 1'b0, '0, '0, 1'b0);

    // Random phases with different stall patterns.
    base = 32'd100;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 67 : 0;
      recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 7 : 0;
      for (int k = 0; k < 23; k++) begin
        send_random_operation(base);
        base = base + $urandom_range(8);
      end
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
